FILE: sv/qli_pkg.sv
// shared types and constants of the quadratic lagrange interpolator
package qli_pkg;

    localparam int GRID_DEPTH = 256;
    localparam int NUM_COLS   = 8;
    localparam int PT_W       = $clog2(GRID_DEPTH);
    localparam int COL_W      = $clog2(NUM_COLS);
    localparam int TAB_AW     = PT_W + COL_W;
    localparam int CFG_W      = 9;
    localparam int PADDR_W    = 3;

    // wide datapath of the term unit
    localparam int WIDE_W     = 104;
    localparam int MB_W       = 48;
    localparam int DEN_W      = 67;
    localparam int DIV_W      = 100;

    localparam logic [1:0] CMD_LOAD_X = 2'd0;
    localparam logic [1:0] CMD_LOAD_Y = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic [7:0]        point_index;
        logic [2:0]        column;
        logic signed [31:0] value;
        logic              order;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result;
        logic [7:0]        centre_index;
        logic              saturated;
        logic              grid_error;
    } t_out_item;

endpackage

FILE: sv/quadratic_lagrange_interpolator_core.sv
// three-point lagrange interpolator on a nonuniform grid, top level
//
// Input channel (i_in_valid / o_in_stall, i_in_item) carries three kinds of
// item: a grid abscissa load, a table value load and a query. Loads write
// the grid or table memory in the cycle they are taken and give no result,
// so loads stream at one item per cycle while no query is in progress. A
// query gives one item on the output channel (o_out_valid / i_out_stall, o_out_item).
// A query scans the grid, then runs the midpoint test and clamp and loads its
// operands, then per term a setup state, three bit-serial products (multiplier
// operands up to 98 bits in all), a 100-bit restoring divider and an
// accumulate, then saturation and the output register.
// The grid and table live in synchronous memories with registered read
// ports; the scan and the term loop are set by these read ports and by
// the shared multiply and divide unit.
// A finished result sits in an output register; while it is stalled, loads
// are still taken, and a following query runs and waits for the register.
// Reset clears control state and sets grid_points_used to 3; memory
// contents are undefined until written. grid_points_used is at address 0
// of the register port.
module quadratic_lagrange_interpolator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  qli_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output qli_pkg::t_out_item          o_out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qli_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import qli_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_SCAN = 13'b0000000000010,
        S_M0   = 13'b0000000000100,
        S_M1   = 13'b0000000001000,
        S_M2   = 13'b0000000010000,
        S_LOAD = 13'b0000000100000,
        S_CHK  = 13'b0000001000000,
        S_TSET = 13'b0000010000000,
        S_MUL  = 13'b0000100000000,
        S_DIV  = 13'b0001000000000,
        S_ACC  = 13'b0010000000000,
        S_SAT  = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } t_state;

    localparam logic [1:0] MS_F12 = 2'd0;
    localparam logic [1:0] MS_Y   = 2'd1;
    localparam logic [1:0] MS_DEN = 2'd2;

    localparam logic signed [WIDE_W-1:0] SUM_MAX = WIDE_W'(64'sh7FFFFFFF);
    localparam logic signed [WIDE_W-1:0] SUM_MIN = -WIDE_W'(64'sh80000000);

    t_state r_state;
    logic [CFG_W-1:0] r_cfg;
    logic [CFG_W-1:0] n_pts;

    logic [31:0] grid_mem  [GRID_DEPTH];
    logic [31:0] table_mem [GRID_DEPTH*NUM_COLS];
    logic [PT_W-1:0]   gaddr;
    logic [TAB_AW-1:0] taddr;
    logic [31:0] r_grd, r_trd;

    logic signed [31:0] r_v;
    logic [COL_W-1:0]   r_col;
    logic               r_ord;
    logic [CFG_W-1:0]   r_k;
    logic               r_pv;
    logic [PT_W-1:0]    r_pk, r_i0, r_c;
    logic signed [31:0] r_xa;
    logic [1:0]         r_j, r_t, r_mstep;
    logic signed [31:0] r_xs [3];
    logic signed [31:0] r_ys [3];
    logic               r_neg;
    logic [MB_W-1:0]    r_ym, r_mb;
    logic [33:0]        r_d1, r_d2;
    logic [WIDE_W-1:0]  r_ma, r_macc, r_num;
    logic [DIV_W-1:0]   r_dq;
    logic [DEN_W:0]     r_rem, r_dvs;
    logic [6:0]         r_dcnt;
    logic signed [WIDE_W-1:0] r_sum;
    t_out_item          r_res, r_out;
    logic               r_out_valid;

    logic in_acc, cfg_wr;
    logic [PT_W-1:0] lidx;

    function automatic logic signed [35:0] sx(input logic signed [31:0] v);
        return {{4{v[31]}}, v};
    endfunction

    function automatic logic [33:0] mag(input logic signed [35:0] v);
        return v[35] ? 34'(-v) : v[33:0];
    endfunction

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign cfg_wr     = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == 1'b0) ? {{(32-CFG_W){1'b0}}, r_cfg} : 32'd0;
    assign n_pts      = (r_cfg > CFG_W'(GRID_DEPTH)) ? CFG_W'(GRID_DEPTH) : r_cfg;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // read address of both memories
    assign lidx = PT_W'(r_c - PT_W'(1) + PT_W'(r_j));
    always_comb begin
        case (r_state)
            S_SCAN:  gaddr = r_k[PT_W-1:0];
            S_M0:    gaddr = r_i0;
            S_M1:    gaddr = PT_W'(r_i0 + PT_W'(1));
            S_LOAD:  gaddr = lidx;
            default: gaddr = '0;
        endcase
    end
    assign taddr = {lidx, r_col};

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_item.command == CMD_LOAD_X) begin
            grid_mem[i_in_item.point_index] <= i_in_item.value;
        end
        r_grd <= grid_mem[gaddr];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_item.command == CMD_LOAD_Y) begin
            table_mem[{i_in_item.point_index, i_in_item.column}] <= i_in_item.value;
        end
        r_trd <= table_mem[taddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_W'(3);
        end else if (cfg_wr) begin
            r_cfg <= pwdata[CFG_W-1:0];
        end
    end

    // midpoint test and clamp
    logic signed [34:0] mid_l, mid_r;
    logic               mid_go;
    logic [CFG_W-1:0]   i1, cl;
    always_comb begin
        mid_l  = 35'(sx(r_v) - sx(r_xa)) <<< 1;
        mid_r  = 35'(sx($signed(r_grd)) - sx(r_xa));
        mid_go = (CFG_W'(r_i0) + CFG_W'(1) < n_pts) && (mid_l > mid_r);
        i1     = CFG_W'(r_i0) + CFG_W'(mid_go);
        cl     = i1;
        if (i1 < CFG_W'(1)) cl = CFG_W'(1);
        if (i1 > n_pts - CFG_W'(2)) cl = n_pts - CFG_W'(2);
    end

    // operands of the current term
    logic signed [31:0] ta, tb, tk, ty;
    logic signed [35:0] e1, e2, ed1, ed2, ey;
    logic               t_neg;
    logic [33:0]        f1, f2, ymag;
    logic [MB_W-1:0]    ym;
    always_comb begin
        case (r_t)
            2'd0:    begin tk = r_xs[0]; ta = r_xs[1]; tb = r_xs[2]; ty = r_ys[0]; end
            2'd1:    begin tk = r_xs[1]; ta = r_xs[2]; tb = r_xs[0]; ty = r_ys[1]; end
            default: begin tk = r_xs[2]; ta = r_xs[0]; tb = r_xs[1]; ty = r_ys[2]; end
        endcase
        e1  = r_ord ? (sx(r_v) + sx(r_v) - sx(ta) - sx(tb)) : (sx(r_v) - sx(ta));
        e2  = sx(r_v) - sx(tb);
        ed1 = sx(tk) - sx(ta);
        ed2 = sx(tk) - sx(tb);
        ey  = sx(ty);
        t_neg = e1[35] ^ (!r_ord && e2[35]) ^ ey[35] ^ ed1[35] ^ ed2[35];
        f1 = mag(e1);
        f2 = r_ord ? 34'd1 : mag(e2);
        ymag = mag(ey);
        ym = r_ord ? {ymag[31:0], 16'd0} : MB_W'(ymag);
    end

    // restoring divider step
    logic [DEN_W+1:0] rem_sh;
    logic             dge;
    assign rem_sh = {r_rem, r_dq[DIV_W-1]};
    assign dge    = rem_sh >= {1'b0, r_dvs};

    logic degen;
    assign degen = (r_xs[0] == r_xs[1]) || (r_xs[0] == r_xs[2]) || (r_xs[1] == r_xs[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_DONE) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in_item.command == CMD_QUERY) begin
                        r_v   <= i_in_item.value;
                        r_col <= i_in_item.column;
                        r_ord <= i_in_item.order;
                        r_k   <= CFG_W'(1);
                        r_pv  <= 1'b0;
                        r_i0  <= '0;
                        if (n_pts < CFG_W'(3)) begin
                            r_res   <= '{result: '0, centre_index: '0,
                                         saturated: 1'b0, grid_error: 1'b1};
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_k < n_pts) begin
                        r_pv <= 1'b1;
                        r_pk <= r_k[PT_W-1:0];
                        r_k  <= r_k + CFG_W'(1);
                    end else begin
                        r_pv <= 1'b0;
                    end
                    if (r_pv && (r_v > $signed(r_grd))) r_i0 <= r_pk;
                    if (r_k >= n_pts && !r_pv) r_state <= S_M0;
                end
                S_M0: r_state <= S_M1;
                S_M1: begin
                    r_xa    <= r_grd;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_c     <= cl[PT_W-1:0];
                    r_j     <= '0;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (r_j != 2'd0) begin
                        r_xs[r_j - 2'd1] <= r_grd;
                        r_ys[r_j - 2'd1] <= r_trd;
                    end
                    r_j <= r_j + 2'd1;
                    if (r_j == 2'd3) r_state <= S_CHK;
                end
                S_CHK: begin
                    r_sum <= '0;
                    r_t   <= '0;
                    if (degen) begin
                        r_res   <= '{result: '0, centre_index: r_c,
                                     saturated: 1'b0, grid_error: 1'b0};
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_TSET;
                    end
                end
                S_TSET: begin
                    r_ma    <= WIDE_W'(f1);
                    r_mb    <= MB_W'(f2);
                    r_macc  <= '0;
                    r_ym    <= ym;
                    r_d1    <= mag(ed1);
                    r_d2    <= mag(ed2);
                    r_neg   <= t_neg;
                    r_mstep <= MS_F12;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_mb == '0) begin
                        case (r_mstep)
                            MS_F12: begin
                                r_ma    <= r_macc;
                                r_mb    <= r_ym;
                                r_macc  <= '0;
                                r_mstep <= MS_Y;
                            end
                            MS_Y: begin
                                r_num   <= r_macc;
                                r_ma    <= WIDE_W'(r_d1);
                                r_mb    <= MB_W'(r_d2);
                                r_macc  <= '0;
                                r_mstep <= MS_DEN;
                            end
                            default: begin
                                // rounded quotient: (2n + d) / 2d
                                r_dq    <= DIV_W'({r_num[WIDE_W-2:0], 1'b0} + r_macc);
                                r_dvs   <= {r_macc[DEN_W-1:0], 1'b0};
                                r_rem   <= '0;
                                r_dcnt  <= '0;
                                r_state <= S_DIV;
                            end
                        endcase
                    end else begin
                        if (r_mb[0]) r_macc <= r_macc + r_ma;
                        r_ma <= r_ma << 1;
                        r_mb <= r_mb >> 1;
                    end
                end
                S_DIV: begin
                    r_rem  <= dge ? DEN_W'(rem_sh - {1'b0, r_dvs}) + (DEN_W+1)'(0)
                                  : rem_sh[DEN_W:0];
                    r_dq   <= {r_dq[DIV_W-2:0], dge};
                    r_dcnt <= r_dcnt + 7'd1;
                    if (r_dcnt == 7'(DIV_W - 1)) r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sum <= r_neg ? r_sum - $signed(WIDE_W'(r_dq))
                                   : r_sum + $signed(WIDE_W'(r_dq));
                    r_t   <= r_t + 2'd1;
                    r_state <= (r_t == 2'd2) ? S_SAT : S_TSET;
                end
                S_SAT: begin
                    r_res.centre_index <= r_c;
                    r_res.grid_error   <= 1'b0;
                    if (r_sum > SUM_MAX) begin
                        r_res.result    <= 32'sh7FFFFFFF;
                        r_res.saturated <= 1'b1;
                    end else if (r_sum < SUM_MIN) begin
                        r_res.result    <= 32'sh80000000;
                        r_res.saturated <= 1'b1;
                    end else begin
                        r_res.result    <= r_sum[31:0];
                        r_res.saturated <= 1'b0;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out       <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/qli_checker.sv
// port-level checks of the interpolator and their binding
module qli_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input qli_pkg::t_out_item o_out_item
);
    import qli_pkg::*;

    // a stalled result item stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result item changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a grid of under three points gives a zero result and centre, not saturated
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.grid_error |->
            o_out_item.result == 32'sd0 && o_out_item.centre_index == 8'd0
            && !o_out_item.saturated)
        else $error("grid error item not clear");

    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.saturated |->
            o_out_item.result == 32'sh7FFFFFFF || o_out_item.result == 32'sh80000000)
        else $error("saturated result not at a rail");

    a_centre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.grid_error |->
            o_out_item.centre_index != 8'd0 && o_out_item.centre_index != 8'd255)
        else $error("centre index out of range");

endmodule

bind quadratic_lagrange_interpolator_core qli_checker u_qli_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

FILE: dv/tb_top.sv
// self-checking testbench of the quadratic lagrange interpolator core
module tb_top;
    import qli_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam longint     Q_MAX      = 64'sd2147483647;
    localparam longint     Q_MIN      = -64'sd2147483648;
    localparam int         HOLD_CYCLES = 3000;

    typedef logic signed [255:0] wide_s;
    typedef logic [255:0]        wide_u;

    // holds the results that accepted queries are due to give, in order
    class result_board;
        t_out_item pending[$];
        int        errors;
        int        checked;

        function void report(string msg);
            $display("ERROR %0t: %s", $realtime, msg);
            errors++;
        endfunction

        function void note_query(t_out_item e);
            pending.push_back(e);
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            checked++;
            if (pending.size() == 0) begin
                report($sformatf("result with no query waiting: %h", got));
                return;
            end
            e = pending.pop_front();
            if (got.result !== e.result)
                report($sformatf("result %h, want %h", got.result, e.result));
            if (got.centre_index !== e.centre_index)
                report($sformatf("centre %0d, want %0d", got.centre_index, e.centre_index));
            if (got.saturated !== e.saturated)
                report($sformatf("saturated %b, want %b", got.saturated, e.saturated));
            if (got.grid_error !== e.grid_error)
                report($sformatf("grid_error %b, want %b", got.grid_error, e.grid_error));
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    t_in_item            i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_item           o_out_item;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    quadratic_lagrange_interpolator_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic signed [31:0] grid_x [GRID_DEPTH];
    logic signed [31:0] tab_y  [GRID_DEPTH*NUM_COLS];
    logic [CFG_W-1:0]   pts_used = 9'd3;

    result_board board = new();
    bit  quiet;
    bit  hold_off;
    bit  pressure_go;
    int  n_loads, n_queries, n_other, n_cfg;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #60000000;
        $display("timeout waiting for results");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_out_item interp_expect(t_in_item it);
        t_out_item r;
        int        n, i0, k;
        longint    v, a, b;
        longint    xs[3], ys[3];
        wide_s     num, den, sum;
        wide_u     mn, md, q;
        logic      neg;
        r = '0;
        n = (pts_used > GRID_DEPTH) ? GRID_DEPTH : pts_used;
        if (n < 3) begin
            r.grid_error = 1'b1;
            return r;
        end
        v  = it.value;
        i0 = 0;
        for (k = 1; k < n; k++)
            if (v > longint'(grid_x[k])) i0 = k;
        // nearer neighbour, only where one follows
        if (i0 + 1 <= n - 1 &&
            2 * (v - longint'(grid_x[i0])) > longint'(grid_x[i0+1]) - longint'(grid_x[i0]))
            i0++;
        if (i0 < 1) i0 = 1;
        if (i0 > n - 2) i0 = n - 2;
        for (k = 0; k < 3; k++) begin
            xs[k] = grid_x[i0-1+k];
            ys[k] = tab_y[(i0-1+k)*NUM_COLS + it.column];
        end
        r.centre_index = i0[7:0];
        if (xs[0] == xs[1] || xs[0] == xs[2] || xs[1] == xs[2]) return r;
        sum = '0;
        for (k = 0; k < 3; k++) begin
            a = xs[(k+1)%3];
            b = xs[(k+2)%3];
            if (it.order == 1'b0)
                num = wide_s'(v - a) * wide_s'(v - b) * wide_s'(ys[k]);
            else
                num = wide_s'(2 * v - a - b) * wide_s'(ys[k]) * 65536;
            den = wide_s'(xs[k] - a) * wide_s'(xs[k] - b);
            neg = num[255] ^ den[255];
            mn  = num[255] ? -num : num;
            md  = den[255] ? -den : den;
            // round to nearest, ties away from zero
            q   = (2 * mn + md) / (2 * md);
            sum = neg ? sum - wide_s'(q) : sum + wide_s'(q);
        end
        if (sum > wide_s'(Q_MAX)) begin
            r.result = 32'h7FFFFFFF;
            r.saturated = 1'b1;
        end else if (sum < wide_s'(Q_MIN)) begin
            r.result = 32'h80000000;
            r.saturated = 1'b1;
        end else begin
            r.result = sum[31:0];
        end
        return r;
    endfunction

    function automatic t_in_item mk(logic [1:0] c, int pi, int col, longint val, bit ord);
        t_in_item it;
        it.command     = c;
        it.point_index = pi[7:0];
        it.column      = col[2:0];
        it.value       = val[31:0];
        it.order       = ord;
        return it;
    endfunction

    function automatic int pick_gap();
        if (quiet || $urandom_range(0, 1) == 0) return 0;
        if ($urandom_range(0, 11) == 0) return $urandom_range(10, 60);
        return $urandom_range(1, 3);
    endfunction

    // called at the edge where an item is taken
    function automatic void absorb(t_in_item it);
        case (it.command)
            CMD_LOAD_X: begin
                grid_x[it.point_index] = it.value;
                n_loads++;
            end
            CMD_LOAD_Y: begin
                tab_y[it.point_index*NUM_COLS + it.column] = it.value;
                n_loads++;
            end
            CMD_QUERY: begin
                board.note_query(interp_expect(it));
                n_queries++;
            end
            default: n_other++;
        endcase
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        absorb(it);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pts_used = data[CFG_W-1:0];
        n_cfg++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic longint rand_y();
        case ($urandom_range(0, 9))
            0: return Q_MAX;
            1: return Q_MIN;
            default: return longint'($signed($urandom())) >>> $urandom_range(0, 16);
        endcase
    endfunction

    // non-descending grid over points 0..cnt-1 followed by the first ncols columns of values
    task automatic build_grid(input int cnt, input longint start, input int max_step,
                              input int ncols, output longint lo, output longint hi);
        longint x;
        int     k, c;
        x  = start;
        lo = start;
        for (k = 0; k < cnt; k++) begin
            send_item(mk(CMD_LOAD_X, k, 0, x, 1'b0));
            hi = x;
            if (k < cnt - 1)
                x = x + (($urandom_range(0, 39) == 0) ? 0 : $urandom_range(4, max_step));
        end
        for (k = 0; k < cnt; k++)
            for (c = 0; c < ncols; c++)
                send_item(mk(CMD_LOAD_Y, k, c, rand_y(), 1'b0));
    endtask

    function automatic t_in_item noise_item(int cmax);
        case ($urandom_range(0, 3))
            0: return mk(CMD_UNUSED, $urandom_range(0, 255), $urandom_range(0, 7),
                         longint'($signed($urandom())), $urandom_range(0, 1));
            1: return mk(CMD_LOAD_X, $urandom_range(0, 255), $urandom_range(0, 7),
                         longint'($signed($urandom())), $urandom_range(0, 1));
            2: return mk(CMD_LOAD_Y, $urandom_range(0, 255), $urandom_range(0, 7),
                         rand_y(), $urandom_range(0, 1));
            default: return mk(CMD_QUERY, $urandom_range(0, 255), $urandom_range(0, cmax),
                               longint'($signed($urandom())), $urandom_range(0, 1));
        endcase
    endfunction

    // result side: check taken results, then pick the stall for the next edge
    initial begin
        int  run_len;
        bit  stall_now;
        run_len   = 0;
        stall_now = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) board.check_result(o_out_item);
            if (run_len == 0) begin
                stall_now = quiet ? 1'b0 : ($urandom_range(0, 2) == 0);
                run_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                        : $urandom_range(1, 4);
            end
            run_len--;
            i_out_stall <= hold_off | stall_now;
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        hold_off = 1'b0;
        wait (pressure_go);
        @(negedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        longint lo, hi, x, d, span, m;
        int     k, n, ph, nq, cmax;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the full grid, values in the first two columns
        quiet = 1'b1;
        apb_write('0, 32'd256);
        build_grid(GRID_DEPTH, Q_MIN, 8000000, 2, lo, hi);
        quiet = 1'b0;

        // directed cases on the full grid
        send_item(mk(CMD_QUERY, 0, 1, Q_MIN, 1'b0));
        send_item(mk(CMD_QUERY, 255, 1, Q_MAX, 1'b1));
        send_item(mk(CMD_QUERY, 0, 0, grid_x[50], 1'b0));
        send_item(mk(CMD_QUERY, 0, 0, grid_x[50], 1'b1));
        // midpoint tie between two points
        d = (longint'(grid_x[62]) - longint'(grid_x[60])) / 4;
        send_item(mk(CMD_LOAD_X, 61, 0, longint'(grid_x[60]) + 2 * d, 1'b0));
        send_item(mk(CMD_QUERY, 0, 1, longint'(grid_x[60]) + d, 1'b0));
        // extreme values around one centre for clipping
        send_item(mk(CMD_LOAD_Y, 70, 2, Q_MAX, 1'b0));
        send_item(mk(CMD_LOAD_Y, 71, 2, Q_MIN, 1'b0));
        send_item(mk(CMD_LOAD_Y, 72, 2, Q_MAX, 1'b0));
        x = longint'(grid_x[71]) + (longint'(grid_x[72]) - longint'(grid_x[71])) / 3;
        send_item(mk(CMD_QUERY, 0, 2, x, 1'b0));
        send_item(mk(CMD_QUERY, 0, 2, x, 1'b1));
        // repeated abscissae
        send_item(mk(CMD_LOAD_X, 101, 0, grid_x[100], 1'b0));
        send_item(mk(CMD_QUERY, 0, 0, grid_x[100], 1'b0));
        send_item(mk(CMD_UNUSED, 255, 7, Q_MIN, 1'b1));
        send_item(mk(CMD_LOAD_X, 255, 7, Q_MAX, 1'b0));
        send_item(mk(CMD_LOAD_Y, 255, 7, Q_MIN, 1'b0));
        send_item(mk(CMD_QUERY, 0, 1, Q_MAX, 1'b1));
        settle();
        // undersized and oversized grid settings
        for (k = 0; k < 3; k++) begin
            apb_write('0, k);
            send_item(mk(CMD_QUERY, 0, k, longint'($signed($urandom())), 1'b0));
            settle();
        end
        apb_write('0, 32'd511);
        send_item(mk(CMD_QUERY, 0, 0, Q_MAX, 1'b0));
        send_item(mk(CMD_QUERY, 0, 1, 0, 1'b1));
        settle();

        ph = 0;
        while (n_loads + n_queries + n_other < 1900) begin
            quiet = (ph % 4 == 1);
            case (ph % 7)
                3: n = 3;
                6: n = 256;
                default: n = $urandom_range(4, 16);
            endcase
            apb_write('0, n);
            nq = (n == 256) ? 20 : 35;
            cmax = (n == 256) ? 1 : NUM_COLS - 1;
            if (n < 256) begin
                build_grid(n, longint'($urandom_range(0, 32'h7FFFFFFF)) - 64'sd1073741824,
                           1 << $urandom_range(4, 24), NUM_COLS, lo, hi);
            end else begin
                lo = grid_x[0];
                hi = grid_x[255];
            end
            if (ph == 2) pressure_go = 1'b1;
            span = hi - lo;
            m    = span / 4 + 1;
            for (k = 0; k < nq; k++) begin
                if ($urandom_range(0, 5) == 0) begin
                    send_item(noise_item(cmax));
                end else begin
                    x = lo - m + longint'({$urandom(), $urandom()} % (span + 2 * m + 1));
                    if (x > Q_MAX) x = Q_MAX;
                    if (x < Q_MIN) x = Q_MIN;
                    send_item(mk(CMD_QUERY, $urandom_range(0, 255), $urandom_range(0, cmax),
                                 x, $urandom_range(0, 1)));
                end
            end
            settle();
            ph++;
        end

        settle();
        repeat (200) @(posedge i_clk);
        $display("covered %0d loads, %0d queries, %0d ignored items over %0d grid settings",
                 n_loads, n_queries, n_other, n_cfg);
        $display("%0d results compared, %0d mismatches", board.checked, board.errors);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/qli_pkg.sv
sv/quadratic_lagrange_interpolator_core.sv
sv/qli_checker.sv
dv/tb_top.sv
